>>> hw/rtl/cfpt_pkg.sv
package cfpt_pkg;

    // width of the numerator and of the quotient in the shared divider
    localparam int DIV_BITS = 32;

    // cadence field width and its saturation value
    localparam int CADENCE_BITS = 8;
    localparam logic [CADENCE_BITS-1:0] CADENCE_SAT = 8'd255;

    // configuration registers
    localparam int CFG_DATA_BITS = 32;
    localparam int LIMIT_BITS    = 3;
    localparam logic CFG_NUMERATOR  = 1'b0;
    localparam logic CFG_IDLE_LIMIT = 1'b1;
    localparam logic [DIV_BITS-1:0]   NUMERATOR_RESET  = 32'd3932160;
    localparam logic [LIMIT_BITS-1:0] IDLE_LIMIT_RESET = 3'd4;

    // request kinds carried in tuser
    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // pulse counter saturates at two
    localparam logic [1:0] PULSES_FULL = 2'd2;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_READ2 = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

endpackage

>>> hw/rtl/cfpt_div.sv
module cfpt_div #(
    parameter int DIVISOR_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cfpt_pkg::DIV_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]       i_divisor,
    output logic                          o_done,
    output logic [cfpt_pkg::DIV_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(cfpt_pkg::DIV_BITS);

    logic [DIVISOR_BITS-1:0]       r_rem;
    logic [DIVISOR_BITS-1:0]       r_divisor;
    logic [cfpt_pkg::DIV_BITS-1:0] r_quot;
    logic [CNT_BITS-1:0]           r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [DIVISOR_BITS:0]         w_shift;
    logic [DIVISOR_BITS:0]         w_sub;
    logic                          w_ge;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    assign w_shift = {r_rem, r_quot[cfpt_pkg::DIV_BITS-1]};
    assign w_ge    = (w_shift >= {1'b0, r_divisor});
    assign w_sub   = w_shift - {1'b0, r_divisor};

    // control: iteration counter and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(cfpt_pkg::DIV_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quot    <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[DIVISOR_BITS-1:0] : w_shift[DIVISOR_BITS-1:0];
            r_quot <= {r_quot[cfpt_pkg::DIV_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hw/rtl/cadence_from_pulse_timestamps.sv
// channel   | direction | tdata                 | tuser
// ----------+-----------+-----------------------+----------------------
// s_axis    | in        | timestamp             | req_type (0 pulse)
// m_axis    | out       | cadence               | idle_reset
// cfg       | in        | numerator / limit     | index 0 / 1
//
// a pulse that yields a cadence goes from acceptance to the next ready through
// evaluate, 32 divider steps, the done strobe, the result hand-over and the
// return to idle; an idle tick that moves the newest slot adds a slot read.
// other items go from evaluate to the hand-over. the radix-2 divider gives one
// quotient bit a cycle; reset is synchronous and needs no clearing pass.
// the output register lets the next request in while a result waits.
module cadence_from_pulse_timestamps #(
    parameter int TIMESTAMP_BITS = 24,
    parameter int RING_DEPTH     = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((TIMESTAMP_BITS+7)/8)*8-1:0] s_axis_tdata,  // timestamp
    input  logic                               s_axis_tuser,  // req_type
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [cfpt_pkg::CADENCE_BITS-1:0]  m_axis_tdata,  // cadence
    output logic                               m_axis_tuser,  // idle_reset
    // configuration
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [cfpt_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int SLOT_BITS = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(RING_DEPTH - 1);

    // configuration registers
    logic [cfpt_pkg::DIV_BITS-1:0]   r_num;
    logic [cfpt_pkg::LIMIT_BITS-1:0] r_limit;

    // measurement state
    cfpt_pkg::t_state                r_state, n_state;
    logic [TIMESTAMP_BITS-1:0]       r_times [RING_DEPTH];
    logic [TIMESTAMP_BITS-1:0]       n_times [RING_DEPTH];
    logic [SLOT_BITS-1:0]            r_wslot, n_wslot;
    logic [1:0]                      r_pseen, n_pseen;
    logic                            r_pst, n_pst;
    logic [cfpt_pkg::LIMIT_BITS-1:0] r_idle, n_idle;
    logic [cfpt_pkg::CADENCE_BITS-1:0] r_cad, n_cad;
    logic                            r_cleared, n_cleared;

    // captured request
    logic                            r_kind;
    logic [TIMESTAMP_BITS-1:0]       r_now;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [cfpt_pkg::CADENCE_BITS-1:0] r_out_cad;
    logic                            r_out_clr;

    // slot arithmetic and the single read port of the ring
    logic [SLOT_BITS-1:0]            w_slot_next;
    logic [SLOT_BITS-1:0]            w_slot_prev;
    logic [SLOT_BITS-1:0]            w_rd_addr;
    logic [TIMESTAMP_BITS-1:0]       w_rd_data;
    logic [TIMESTAMP_BITS-1:0]       w_diff;
    logic                            w_do_rate;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [cfpt_pkg::DIV_BITS-1:0]   w_quot;
    logic                            w_accept;

    assign w_slot_next = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
    assign w_slot_prev = (r_wslot == '0) ? LAST_SLOT : r_wslot - 1'b1;

    // read address follows the sequencer step
    always_comb begin
        case (r_state)
            cfpt_pkg::ST_EVAL:
                w_rd_addr = (r_kind == cfpt_pkg::REQ_PULSE) ? w_slot_next : w_slot_prev;
            default:
                w_rd_addr = r_wslot;
        endcase
    end

    assign w_rd_data = r_times[w_rd_addr];
    assign w_diff    = r_now - w_rd_data;
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == cfpt_pkg::ST_IDLE);

    // shared divider: numerator over wrapped period
    cfpt_div #(
        .DIVISOR_BITS(TIMESTAMP_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_num),
        .i_divisor  (w_diff),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // sequencer and state update
    always_comb begin
        n_state     = r_state;
        n_times     = r_times;
        n_wslot     = r_wslot;
        n_pseen     = r_pseen;
        n_pst       = r_pst;
        n_idle      = r_idle;
        n_cad       = r_cad;
        n_cleared   = r_cleared;
        n_out_valid = r_out_valid;
        w_do_rate   = 1'b0;
        w_div_start = 1'b0;

        // the waiting result leaves when taken
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            cfpt_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cleared = 1'b0;
                    n_state   = cfpt_pkg::ST_EVAL;
                end
            end
            cfpt_pkg::ST_EVAL: begin
                n_state = cfpt_pkg::ST_DONE;
                if (r_kind == cfpt_pkg::REQ_PULSE) begin
                    // store pulse, rate against the oldest slot
                    n_times[r_wslot] = r_now;
                    n_wslot = w_slot_next;
                    n_pst   = 1'b1;
                    if (r_pseen < cfpt_pkg::PULSES_FULL) begin
                        n_pseen = r_pseen + 1'b1;
                    end
                    if (r_pseen != '0) begin
                        w_do_rate = 1'b1;
                    end
                end else if (r_pst) begin
                    n_pst = 1'b0;
                end else if (r_idle >= r_limit) begin
                    // idle too long: clear the measurement
                    for (int i = 0; i < RING_DEPTH; i++) begin
                        n_times[i] = '0;
                    end
                    n_wslot   = '0;
                    n_pseen   = '0;
                    n_idle    = '0;
                    n_cad     = '0;
                    n_cleared = 1'b1;
                end else begin
                    // decay: move the newest nonzero slot to now
                    n_idle = r_idle + 1'b1;
                    if (w_rd_data != '0) begin
                        n_times[w_slot_prev] = r_now;
                        n_state = cfpt_pkg::ST_READ2;
                    end
                end
            end
            cfpt_pkg::ST_READ2: begin
                w_do_rate = 1'b1;
            end
            cfpt_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_cad   = (|w_quot[cfpt_pkg::DIV_BITS-1:cfpt_pkg::CADENCE_BITS])
                              ? cfpt_pkg::CADENCE_SAT
                              : w_quot[cfpt_pkg::CADENCE_BITS-1:0];
                    n_state = cfpt_pkg::ST_DONE;
                end
            end
            cfpt_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_state     = cfpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cfpt_pkg::ST_IDLE;
            end
        endcase

        // zero period saturates, otherwise start the divider
        if (w_do_rate) begin
            if (w_diff == '0) begin
                n_cad   = cfpt_pkg::CADENCE_SAT;
                n_state = cfpt_pkg::ST_DONE;
            end else begin
                w_div_start = 1'b1;
                n_state     = cfpt_pkg::ST_DIV;
            end
        end
    end

    // control and measurement registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfpt_pkg::ST_IDLE;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_times[i] <= '0;
            end
            r_wslot     <= '0;
            r_pseen     <= '0;
            r_pst       <= 1'b0;
            r_idle      <= '0;
            r_cad       <= '0;
            r_cleared   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_times     <= n_times;
            r_wslot     <= n_wslot;
            r_pseen     <= n_pseen;
            r_pst       <= n_pst;
            r_idle      <= n_idle;
            r_cad       <= n_cad;
            r_cleared   <= n_cleared;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num   <= cfpt_pkg::NUMERATOR_RESET;
            r_limit <= cfpt_pkg::IDLE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfpt_pkg::CFG_NUMERATOR:  r_num   <= i_cfg_data;
                cfpt_pkg::CFG_IDLE_LIMIT: r_limit <= i_cfg_data[cfpt_pkg::LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= s_axis_tuser;
            r_now  <= s_axis_tdata[TIMESTAMP_BITS-1:0];
        end
        if ((r_state == cfpt_pkg::ST_DONE) && (!r_out_valid || m_axis_tready)) begin
            r_out_cad <= r_cad;
            r_out_clr <= r_cleared;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_cad;
    assign m_axis_tuser  = r_out_clr;

    // divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == cfpt_pkg::ST_DIV))
        else $error("divider finished outside its wait state");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("request taken while one is in progress");

    // pulse counter never passes its saturation point
    a_pseen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pseen <= cfpt_pkg::PULSES_FULL)
        else $error("pulse counter beyond saturation");

    // a clearing result always reports zero cadence
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("idle clear with nonzero cadence");

    // write slot stays inside the ring
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wslot <= LAST_SLOT)
        else $error("write slot outside the ring");

endmodule

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TS_BITS        = 24;
    localparam int RING           = 3;
    localparam int LIM_BITS       = cfpt_pkg::LIMIT_BITS;
    localparam int LATENCY_CYCLES = 40;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 400;

    typedef enum {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} t_gap_mode;

    typedef struct packed {
        logic               kind;
        logic [TS_BITS-1:0] stamp;
    } t_cad_request;

    typedef struct packed {
        logic [cfpt_pkg::CADENCE_BITS-1:0] cadence;
        logic                              idle_reset;
    } t_cad_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [TS_BITS-1:0]                 s_axis_tdata;   // timestamp
    logic                               s_axis_tuser;   // req_type
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [cfpt_pkg::CADENCE_BITS-1:0]  m_axis_tdata;   // cadence
    logic                               m_axis_tuser;   // idle_reset
    logic                               i_cfg_we;
    logic                               i_cfg_idx;
    logic [cfpt_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    cadence_from_pulse_timestamps dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state and its copy of the registers
    logic [TS_BITS-1:0]                stamp_ring [RING];
    int unsigned                       ring_wr;
    logic [1:0]                        pulse_cnt;
    bit                                pulse_flag;
    logic [LIM_BITS-1:0]               idle_ticks;
    logic [cfpt_pkg::CADENCE_BITS-1:0] cadence_now;
    logic [cfpt_pkg::DIV_BITS-1:0]     numerator_cfg;
    logic [LIM_BITS-1:0]               limit_cfg;

    t_cad_request       request_queue [$];
    t_cad_result        cadence_expected [$];
    t_cad_request       head_req;
    t_cad_request       taken_req;
    t_cad_result        predicted;
    t_cad_result        want;
    t_gap_mode          gap_mode;
    bit                 req_taken;
    bit                 res_taken;
    bit                 hold_req;
    int                 hold_left;
    int                 quiet_cycles;
    int                 mismatches;
    logic [TS_BITS-1:0] stamp_clock;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_ring();
        for (int i = 0; i < RING; i++) stamp_ring[i] = '0;
        ring_wr    = 0;
        pulse_cnt  = '0;
        idle_ticks = '0;
        cadence_now = '0;
    endfunction

    // wrapped period to rpm, saturated
    function automatic logic [cfpt_pkg::CADENCE_BITS-1:0] cadence_from_gap(
        logic [TS_BITS-1:0] now_ts, logic [TS_BITS-1:0] then_ts);
        logic [TS_BITS-1:0]            gap;
        logic [cfpt_pkg::DIV_BITS-1:0] quot;
        gap = now_ts - then_ts;
        if (gap == '0) return cfpt_pkg::CADENCE_SAT;
        quot = numerator_cfg / {{(cfpt_pkg::DIV_BITS-TS_BITS){1'b0}}, gap};
        return (quot > 32'd255) ? cfpt_pkg::CADENCE_SAT
                                : quot[cfpt_pkg::CADENCE_BITS-1:0];
    endfunction

    // advance the predicted meter by one request
    function automatic t_cad_result cadence_update(t_cad_request req);
        t_cad_result res;
        int unsigned newest;
        res.idle_reset = 1'b0;
        if (req.kind == cfpt_pkg::REQ_PULSE) begin
            if (pulse_cnt < cfpt_pkg::PULSES_FULL) pulse_cnt = pulse_cnt + 2'd1;
            pulse_flag = 1'b1;
            stamp_ring[ring_wr] = req.stamp;
            ring_wr = (ring_wr + 1) % RING;
            if (pulse_cnt >= cfpt_pkg::PULSES_FULL)
                cadence_now = cadence_from_gap(req.stamp, stamp_ring[ring_wr]);
        end else if (pulse_flag) begin
            pulse_flag = 1'b0;
        end else if (idle_ticks >= limit_cfg) begin
            clear_ring();
            res.idle_reset = 1'b1;
        end else begin
            newest = (ring_wr + RING - 1) % RING;
            idle_ticks = idle_ticks + 3'd1;
            // decay: the newest pulse is pulled forward to now
            if (stamp_ring[newest] != '0) begin
                stamp_ring[newest] = req.stamp;
                cadence_now = cadence_from_gap(req.stamp, stamp_ring[ring_wr]);
            end
        end
        res.cadence = cadence_now;
        return res;
    endfunction

    function automatic bit gap_roll(bit for_sender);
        case (gap_mode)
            GAP_SENDER:   return for_sender && ($urandom_range(99) < 52);
            GAP_RECEIVER: return !for_sender && ($urandom_range(99) < 52);
            GAP_BOTH:     return $urandom_range(99) < 8;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic logic [TS_BITS-1:0] pick_gap();
        case ($urandom_range(9))
            0:       return TS_BITS'($urandom_range(3));
            1:       return TS_BITS'($urandom);
            2:       return TS_BITS'($urandom_range(1, 1000));
            default: return TS_BITS'($urandom_range(1000, 60000));
        endcase
    endfunction

    function automatic void add_request(logic kind, logic [TS_BITS-1:0] stamp);
        t_cad_request req;
        req.kind  = kind;
        req.stamp = stamp;
        request_queue.push_back(req);
    endfunction

    task automatic note_error(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (request_queue.size() != 0 && !gap_roll(1'b1)) begin
                head_req = request_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= head_req.stamp;
                s_axis_tuser  <= head_req.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result acceptance, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !gap_roll(1'b0);
        end
    end

    // prediction, result check and watchdog
    always @(posedge i_clk) begin
        req_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        res_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (req_taken) begin
            taken_req.kind  = s_axis_tuser;
            taken_req.stamp = s_axis_tdata;
            predicted = cadence_update(taken_req);
            cadence_expected.push_back(predicted);
        end
        if (res_taken) begin
            if (cadence_expected.size() == 0) begin
                note_error($sformatf("unexpected result cadence %0d idle_reset %0b",
                                     m_axis_tdata, m_axis_tuser));
            end else begin
                want = cadence_expected.pop_front();
                if (m_axis_tdata !== want.cadence)
                    note_error($sformatf("cadence expected %0d got %0d",
                                         want.cadence, m_axis_tdata));
                if (m_axis_tuser !== want.idle_reset)
                    note_error($sformatf("idle_reset expected %0b got %0b",
                                         want.idle_reset, m_axis_tuser));
            end
        end
        if (req_taken || res_taken) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (request_queue.size() != 0 || s_axis_tvalid || cadence_expected.size() != 0);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [cfpt_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == cfpt_pkg::CFG_NUMERATOR) numerator_cfg = value;
        else limit_cfg = value[LIM_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // bursts of pulses followed by runs of ticks, with some noise mixed in
    task automatic fill_random(int count);
        int added;
        int n_pulses;
        int n_ticks;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 15) begin
                add_request(1'($urandom_range(1)), TS_BITS'($urandom));
                added++;
            end else begin
                n_pulses = $urandom_range(1, 6);
                n_ticks  = $urandom_range(0, 9);
                repeat (n_pulses) begin
                    stamp_clock = stamp_clock + pick_gap();
                    add_request(cfpt_pkg::REQ_PULSE, stamp_clock);
                    added++;
                end
                repeat (n_ticks) begin
                    stamp_clock = stamp_clock + TS_BITS'($urandom_range(1, 1 << 20));
                    add_request(cfpt_pkg::REQ_TICK, stamp_clock);
                    added++;
                end
            end
        end
    endtask

    task automatic run_phase(logic [cfpt_pkg::DIV_BITS-1:0] num, logic [LIM_BITS-1:0] lim,
                             t_gap_mode mode, int count, bit squeeze);
        wait_drained();
        write_reg(cfpt_pkg::CFG_NUMERATOR, num);
        write_reg(cfpt_pkg::CFG_IDLE_LIMIT,
                  {{(cfpt_pkg::CFG_DATA_BITS-LIM_BITS){1'b0}}, lim});
        @(posedge i_clk);
        gap_mode = mode;
        fill_random(count);
        if (squeeze) hold_req = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = cfpt_pkg::REQ_PULSE;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = cfpt_pkg::CFG_NUMERATOR;
        i_cfg_data    = '0;
        gap_mode      = GAP_NONE;
        req_taken     = 1'b0;
        res_taken     = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        quiet_cycles  = 0;
        mismatches    = 0;
        stamp_clock   = '0;
        pulse_flag    = 1'b0;
        numerator_cfg = cfpt_pkg::NUMERATOR_RESET;
        limit_cfg     = cfpt_pkg::IDLE_LIMIT_RESET;
        clear_ring();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero stamps, zero period, wrap-around, decay and the idle clear
        add_request(cfpt_pkg::REQ_PULSE, 24'h000000);
        add_request(cfpt_pkg::REQ_PULSE, 24'h000000);
        add_request(cfpt_pkg::REQ_TICK,  24'h000100);
        add_request(cfpt_pkg::REQ_TICK,  24'h000200);
        add_request(cfpt_pkg::REQ_PULSE, 24'hFFFFFF);
        add_request(cfpt_pkg::REQ_PULSE, 24'h000010);
        add_request(cfpt_pkg::REQ_PULSE, 24'h03C000);
        add_request(cfpt_pkg::REQ_TICK,  24'h040000);
        add_request(cfpt_pkg::REQ_TICK,  24'h050000);
        add_request(cfpt_pkg::REQ_TICK,  24'h060000);
        add_request(cfpt_pkg::REQ_TICK,  24'h070000);
        add_request(cfpt_pkg::REQ_TICK,  24'h080000);
        add_request(cfpt_pkg::REQ_TICK,  24'h090000);
        add_request(cfpt_pkg::REQ_TICK,  24'h0A0000);
        add_request(cfpt_pkg::REQ_PULSE, 24'h800000);
        add_request(cfpt_pkg::REQ_PULSE, 24'h803C00);
        add_request(cfpt_pkg::REQ_PULSE, 24'h807800);
        add_request(cfpt_pkg::REQ_TICK,  24'hFFFFFF);
        add_request(cfpt_pkg::REQ_TICK,  24'h000001);
        add_request(cfpt_pkg::REQ_PULSE, 24'hAAAAAA);
        add_request(cfpt_pkg::REQ_PULSE, 24'h555555);
        add_request(cfpt_pkg::REQ_TICK,  24'h555556);

        run_phase(32'hFFFF_FFFF, 3'd7, GAP_SENDER, 80, 1'b0);
        run_phase(32'd1, 3'd1, GAP_RECEIVER, 80, 1'b1);
        run_phase(cfpt_pkg::NUMERATOR_RESET, 3'd0, GAP_BOTH, 80, 1'b0);
        run_phase(32'd1_000_000, 3'd3, GAP_NONE, 70, 1'b0);
        run_phase($urandom_range(100000, 20000000), LIM_BITS'($urandom_range(1, 7)),
                  GAP_SENDER, 80, 1'b0);
        run_phase(cfpt_pkg::NUMERATOR_RESET, cfpt_pkg::IDLE_LIMIT_RESET, GAP_BOTH, 80, 1'b0);
        run_phase(32'd500_000, 3'd2, GAP_RECEIVER, 60, 1'b0);
        wait_drained();

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
